// ===== rtl/bfd_pkg.sv =====
// ---------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the box filter downscaler
// Register indexes, field widths and the request records between the
// position tracker, the accumulator memory and the divider.
// ---------------------------------------------------------------------------
package bfd_pkg;

	localparam int DEF_MAX_DIM = 4096;
	localparam int REG_W = 13;
	localparam int POS_W = 12;
	localparam int CH_W = 8;
	localparam int SUM_W = 32;
	localparam int CNT_W = 24;

	localparam logic [2:0] REG_SRC_W = 3'd0;
	localparam logic [2:0] REG_SRC_H = 3'd1;
	localparam logic [2:0] REG_DST_W = 3'd2;
	localparam logic [2:0] REG_DST_H = 3'd3;
	localparam logic [2:0] REG_BOX_W = 3'd4;
	localparam logic [2:0] REG_BOX_H = 3'd5;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
		logic [CNT_W-1:0] cnt;
	} acc_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             fend;
	} tag_t;

endpackage

// ===== rtl/bfd_div.sv =====
// ---------------------------------------------------------------------------
// bfd_div: sequential averaging divider
// Restoring division of the three channel sums by the count, one quotient
// bit per cycle, the three channels in parallel.
// ---------------------------------------------------------------------------
module bfd_div
	import bfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  acc_t              acc,
	input  tag_t              tag_in,
	output logic              busy,
	output logic              done,
	output pix_t              avg,
	output tag_t              tag_out
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [SUM_W-1:0]  qb_q, qg_q, qr_q;
	logic [CNT_W:0]    rb_q, rg_q, rr_q;
	logic [CNT_W-1:0]  d_q;
	tag_t              tag_q;

	logic [CNT_W:0] rb_n, rg_n, rr_n;
	logic [CNT_W:0] db;

	assign db = {1'b0, d_q};
	assign rb_n = {rb_q[CNT_W-1:0], qb_q[SUM_W-1]};
	assign rg_n = {rg_q[CNT_W-1:0], qg_q[SUM_W-1]};
	assign rr_n = {rr_q[CNT_W-1:0], qr_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			qb_q <= acc.blue;
			qg_q <= acc.green;
			qr_q <= acc.red;
			rb_q <= '0;
			rg_q <= '0;
			rr_q <= '0;
			d_q <= (acc.cnt == '0) ? CNT_W'(1) : acc.cnt;
			tag_q <= tag_in;
		end else if (busy_q) begin
			if (rb_n >= db) begin
				rb_q <= rb_n - db;
				qb_q <= {qb_q[SUM_W-2:0], 1'b1};
			end else begin
				rb_q <= rb_n;
				qb_q <= {qb_q[SUM_W-2:0], 1'b0};
			end
			if (rg_n >= db) begin
				rg_q <= rg_n - db;
				qg_q <= {qg_q[SUM_W-2:0], 1'b1};
			end else begin
				rg_q <= rg_n;
				qg_q <= {qg_q[SUM_W-2:0], 1'b0};
			end
			if (rr_n >= db) begin
				rr_q <= rr_n - db;
				qr_q <= {qr_q[SUM_W-2:0], 1'b1};
			end else begin
				rr_q <= rr_n;
				qr_q <= {qr_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign avg = '{blue: qb_q[CH_W-1:0], green: qg_q[CH_W-1:0], red: qr_q[CH_W-1:0]};
	assign tag_out = tag_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_no_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> step_q == '0) else $error("step not cleared");
`endif

endmodule

// ===== rtl/bfd_acc.sv =====
// ---------------------------------------------------------------------------
// bfd_acc: column accumulator memory
// One entry per destination column holding the channel sums and the count.
// Read, then added and written back in the following cycle, with forwarding of
// the entry just written; reset or a restart starts a pass clearing all entries.
// ---------------------------------------------------------------------------
module bfd_acc
	import bfd_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	output logic                       clearing,
	input  logic                       rd_en,
	input  logic [$clog2(MAX_DIM)-1:0] rd_addr,
	input  logic                       upd_en,
	input  logic [$clog2(MAX_DIM)-1:0] upd_addr,
	input  pix_t                       upd_pix,
	input  logic                       upd_zero,
	output acc_t                       upd_sum
);

	localparam int AW = $clog2(MAX_DIM);

	acc_t            mem [MAX_DIM];
	acc_t            rdata_q;
	logic [AW-1:0]   rd_addr_q;
	logic            fwd_q;
	acc_t            wdata;
	acc_t            last_q;
	logic            clr_q;
	logic [AW:0]     clr_cnt_q;
	acc_t            base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (restart) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (AW+1)'(MAX_DIM - 1)) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
			fwd_q <= upd_en && (upd_addr == rd_addr);
		end
		if (clr_q) mem[clr_cnt_q[AW-1:0]] <= '0;
		else if (upd_en) mem[upd_addr] <= upd_zero ? '0 : wdata;
		if (upd_en) last_q <= upd_zero ? '0 : wdata;
	end

	assign base = fwd_q ? last_q : rdata_q;

	always_comb begin
		wdata.blue = base.blue + SUM_W'(upd_pix.blue);
		wdata.green = base.green + SUM_W'(upd_pix.green);
		wdata.red = base.red + SUM_W'(upd_pix.red);
		wdata.cnt = base.cnt + 1'b1;
	end

	assign upd_sum = wdata;
	assign clearing = clr_q;

`ifndef SYNTH
	a_addr_match: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |-> upd_addr == rd_addr_q) else $error("update address mismatch");
	a_no_upd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !upd_en) else $error("update during clear");
`endif

endmodule

// ===== rtl/bfd_pos.sv =====
// ---------------------------------------------------------------------------
// bfd_pos: source and destination position tracker
// Walks the source raster and keeps the destination column and row with
// incremental remainders, flagging the last pixel of each column group and
// row band. The per-pixel steps dw/sw and dh/sh are divided out after each
// restart or reset, before the first pixel can arrive.
// ---------------------------------------------------------------------------
module bfd_pos
	import bfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic             adv,
	input  logic [REG_W-1:0] sw,
	input  logic [REG_W-1:0] sh,
	input  logic [REG_W-1:0] dw,
	input  logic [REG_W-1:0] dh,
	output logic [REG_W-1:0] dx,
	output logic [REG_W-1:0] dy,
	output logic             last_col,
	output logic             last_row,
	output logic             last_x,
	output logic             last_y
);

	logic [REG_W-1:0] sx_q, sy_q;
	logic [REG_W-1:0] dx_q, dy_q;
	logic [REG_W-1:0] ex_q, ey_q;
	logic [REG_W:0]   ex_s, ey_s;
	logic             cx, cy;
	logic [REG_W-1:0] qx_q, qy_q;
	logic [REG_W-1:0] rx_q, ry_q;
	logic             ld_q, run_q;
	logic [3:0]       cnt_q;
	logic [REG_W:0]   rxn, ryn;

	// step quotient and remainder: dw/sw and dh/sh, one bit per cycle
	assign rxn = {rx_q, qx_q[REG_W-1]};
	assign ryn = {ry_q, qy_q[REG_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q <= 1'b1; run_q <= 1'b0; cnt_q <= '0;
			qx_q <= '0; qy_q <= '0; rx_q <= '0; ry_q <= '0;
		end else if (restart) begin
			ld_q <= 1'b1; run_q <= 1'b0;
		end else if (ld_q) begin
			ld_q <= 1'b0; run_q <= 1'b1; cnt_q <= '0;
			qx_q <= dw; qy_q <= dh; rx_q <= '0; ry_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 4'(REG_W - 1)) run_q <= 1'b0;
			if (rxn >= {1'b0, sw}) begin
				rx_q <= REG_W'(rxn - {1'b0, sw});
				qx_q <= {qx_q[REG_W-2:0], 1'b1};
			end else begin
				rx_q <= rxn[REG_W-1:0];
				qx_q <= {qx_q[REG_W-2:0], 1'b0};
			end
			if (ryn >= {1'b0, sh}) begin
				ry_q <= REG_W'(ryn - {1'b0, sh});
				qy_q <= {qy_q[REG_W-2:0], 1'b1};
			end else begin
				ry_q <= ryn[REG_W-1:0];
				qy_q <= {qy_q[REG_W-2:0], 1'b0};
			end
		end
	end

	// next remainder: e + step remainder; both below s, so at most one carry
	assign ex_s = {1'b0, ex_q} + {1'b0, rx_q};
	assign ey_s = {1'b0, ey_q} + {1'b0, ry_q};
	assign cx = ex_s >= {1'b0, sw};
	assign cy = ey_s >= {1'b0, sh};

	assign last_x = (sx_q + 1'b1) == sw;
	assign last_y = (sy_q + 1'b1) == sh;
	assign last_col = last_x || cx || (qx_q != '0);
	assign last_row = last_y || cy || (qy_q != '0);
	assign dx = dx_q;
	assign dy = dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0; dx_q <= '0; dy_q <= '0; ex_q <= '0; ey_q <= '0;
		end else if (restart) begin
			sx_q <= '0; sy_q <= '0; dx_q <= '0; dy_q <= '0; ex_q <= '0; ey_q <= '0;
		end else if (adv) begin
			if (last_x) begin
				sx_q <= '0; dx_q <= '0; ex_q <= '0;
				if (last_y) begin
					sy_q <= '0; dy_q <= '0; ey_q <= '0;
				end else begin
					sy_q <= sy_q + 1'b1;
					dy_q <= dy_q + qy_q + REG_W'(cy);
					ey_q <= cy ? REG_W'(ey_s - {1'b0, sh}) : ey_s[REG_W-1:0];
				end
			end else begin
				sx_q <= sx_q + 1'b1;
				dx_q <= dx_q + qx_q + REG_W'(cx);
				ex_q <= cx ? REG_W'(ex_s - {1'b0, sw}) : ex_s[REG_W-1:0];
			end
		end
	end

`ifndef SYNTH
	a_sx_range: assert property (@(posedge clk) disable iff (!arst_n)
		sx_q < sw || $past(restart) || !$stable(sw)) else $error("column out of range");
	a_ex_range: assert property (@(posedge clk) disable iff (!arst_n)
		ex_q < sw || !$stable(sw) || !$stable(dw)) else $error("remainder out of range");
	a_no_adv_div: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> !ld_q && !run_q) else $error("advance before step is ready");
`endif

endmodule

// ===== rtl/box_filter_downscaler.sv =====
// ---------------------------------------------------------------------------
// box_filter_downscaler: area-average downscaler with letterbox placement
// A completing pixel's result passes the memory update, 32 divide steps and one
// output register before it is valid.
// Throughput: one pixel per cycle; a completing pixel holds the input until its
// result is registered, longer while the previous result waits at the output.
// Reset or any register write starts a clearing pass over all MAX_DIM entries;
// no pixel is accepted until it ends.
// ---------------------------------------------------------------------------
module box_filter_downscaler
	import bfd_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // src_blue, src_green, src_red
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_x, out_y, avg_blue, avg_green, avg_red
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = $clog2(MAX_DIM);

	logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q, box_w_q, box_h_q;
	logic [REG_W-1:0] sw, sh, dw, dh;
	logic             cfg_wr;
	logic             clearing;
	logic             accept;
	logic             upd_s1;
	pix_t             pix_s1;
	logic             emit_s1;
	tag_t             tag_s1;
	logic [AW-1:0]    addr_s1;
	logic [REG_W-1:0] dx, dy;
	logic             last_col, last_row, last_x, last_y;
	acc_t             upd_sum;
	logic             div_busy, div_done;
	pix_t             avg;
	tag_t             tag_out;
	logic             pend_q;
	logic             outv_q;
	pix_t             out_pix_q;
	tag_t             out_tag_q;
	logic [REG_W-1:0] offx, offy;

	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
		logic [REG_W-1:0] r;
		r = v;
		if (v == '0) r = REG_W'(1);
		if (32'(v) > MAX_DIM) r = REG_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [REG_W-1:0] bar_off(input logic [REG_W-1:0] box,
			input logic [REG_W-1:0] pic);
		logic [REG_W-1:0] d;
		d = box - pic;
		return (box < pic) ? '0 : {1'b0, d[REG_W-1:2], 1'b0};
	endfunction

	assign sw = clamp_dim(src_w_q);
	assign sh = clamp_dim(src_h_q);
	assign dw = clamp_dim(dst_w_q);
	assign dh = clamp_dim(dst_h_q);
	assign offx = bar_off(box_w_q, dw);
	assign offy = bar_off(box_h_q, dh);

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= REG_W'(1920); src_h_q <= REG_W'(1080);
			dst_w_q <= REG_W'(1280); dst_h_q <= REG_W'(720);
			box_w_q <= REG_W'(1280); box_h_q <= REG_W'(720);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_DST_W: dst_w_q <= cfg_data;
				REG_DST_H: dst_h_q <= cfg_data;
				REG_BOX_W: box_w_q <= cfg_data;
				REG_BOX_H: box_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold input while a completed pixel is updated or divided; hold a completing
	// pixel while the output register is still full
	assign s_tready = !clearing && !cfg_wr && !pend_q && !(upd_s1 && emit_s1) &&
		!(outv_q && last_col && last_row);
	assign accept = s_tvalid && s_tready;

	bfd_pos u_pos (
		.clk(clk), .arst_n(arst_n), .restart(cfg_wr), .adv(accept),
		.sw(sw), .sh(sh), .dw(dw), .dh(dh),
		.dx(dx), .dy(dy), .last_col(last_col), .last_row(last_row),
		.last_x(last_x), .last_y(last_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
		end else begin
			upd_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= '{blue: s_tdata[7:0], green: s_tdata[15:8], red: s_tdata[23:16]};
			emit_s1 <= last_col && last_row;
			addr_s1 <= dx[AW-1:0];
			tag_s1.x <= POS_W'(offx + dx);
			tag_s1.y <= POS_W'(offy + dy);
			tag_s1.fend <= last_x && last_y;
		end
	end

	bfd_acc #(.MAX_DIM(MAX_DIM)) u_acc (
		.clk(clk), .arst_n(arst_n), .restart(cfg_wr), .clearing(clearing),
		.rd_en(accept), .rd_addr(dx[AW-1:0]),
		.upd_en(upd_s1), .upd_addr(addr_s1), .upd_pix(pix_s1),
		.upd_zero(emit_s1), .upd_sum(upd_sum)
	);

	bfd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(upd_s1 && emit_s1), .acc(upd_sum),
		.tag_in(tag_s1), .busy(div_busy), .done(div_done), .avg(avg), .tag_out(tag_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			if (upd_s1 && emit_s1) pend_q <= 1'b1;
			else if (div_done) pend_q <= 1'b0;
			if (div_done) outv_q <= 1'b1;
			else if (m_tready) outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			out_pix_q <= avg;
			out_tag_q <= tag_out;
		end
	end

	assign m_tvalid = outv_q;
	assign m_tdata = {out_pix_q.red, out_pix_q.green, out_pix_q.blue, out_tag_q.y, out_tag_q.x};
	assign m_tlast = out_tag_q.fend;

`ifndef SYNTH
	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> pend_q && !outv_q) else $error("divide without pending");
	a_no_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !accept) else $error("accept while pending");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept) else $error("accept while clearing");
`endif

endmodule
